// File: hdl/mfrbp_pkg.sv
// shared types and constants of the motion-capture frame rigid-body parser
`default_nettype none
package mfrbp_pkg;

   localparam int DefCountBits = 32;
   localparam logic [15:0] FRAME_MSG_ID = 16'd7;
   localparam int RecWords = 9;
   localparam int RwBits = 4;
   localparam logic [RwBits-1:0] RW_POS_Z = 4'd3;
   localparam logic [RwBits-1:0] RW_LAST = 4'd8;

   typedef enum logic [3:0] {
      PH_MSG_ID,
      PH_LENGTH,
      PH_FRAME,
      PH_NSETS,
      PH_SET_NAME,
      PH_SET_COUNT,
      PH_SKIP_SET,
      PH_OTHER_COUNT,
      PH_SKIP_OTHER,
      PH_BODY_COUNT,
      PH_BODY,
      PH_IDLE
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic signed [31:0] body_id;
      logic signed [31:0] frame_number;
      logic [31:0]        pos_x;
      logic [31:0]        pos_y;
      logic [31:0]        pos_z;
      logic [31:0]        quat_x;
      logic [31:0]        quat_y;
      logic [31:0]        quat_z;
      logic [31:0]        quat_w;
      logic [31:0]        mean_error;
      logic               tracked;
      logic               last_body;
   } rsp_type;

   typedef logic [2:0][31:0] pos_type;

endpackage
`default_nettype wire

// File: hdl/mocap_frame_rigid_body_parser.sv
// top level: byte-stream frame parser giving one item per rigid body record
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  req     | in        | req_valid/req_stall | req_data: datagram byte + eop
//  rsp     | out       | rsp_valid/rsp_stall | rsp_data: one rigid body record
//
// one byte is taken every cycle unless req_stall is high; a rigid body item enters
// the rsp register in the cycle after its last record byte is taken, held there until taken
// req_stall rises only while the parser waits on the last byte of a record and
// the rsp register still holds an item that the far side stalls
// reset is synchronous, no clearing pass; record and position
// stores hold no defined value until written
`default_nettype none
module mocap_frame_rigid_body_parser #(
   parameter int COUNT_BITS = mfrbp_pkg::DefCountBits
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mfrbp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mfrbp_pkg::rsp_type rsp_data
);
   import mfrbp_pkg::*;

   localparam int SkipBits = COUNT_BITS + 4;

   // parser state
   phase_type             phase_ff, phase_in;
   logic [1:0]            bif_ff, bif_in;          // byte within current field
   logic [31:0]           asm_ff, asm_in;          // field assembly
   logic                  kind_frame_ff, kind_frame_in;
   logic [COUNT_BITS-1:0] sets_ff, sets_in;
   logic [SkipBits-1:0]   skip_ff, skip_in;
   logic [COUNT_BITS-1:0] bodies_ff, bodies_in;
   logic [RwBits-1:0]     rw_ff, rw_in;            // word index within body record

   // payload stores
   logic [7:0][31:0]      rec_ff;
   logic                  rec_we;
   logic [31:0]           frame_ff;
   logic                  frame_we;
   pos_type               prev_pos_ff;
   logic                  pos_we;
   logic                  seen_ff, seen_in;
   logic                  tracked_ff, tracked_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   logic                  req_fire;
   logic                  emit_pending;
   logic                  emit;
   logic [31:0]           cur_field;               // field value including this byte
   logic                  field2_done, field4_done;
   logic [COUNT_BITS-1:0] cnt;
   logic [SkipBits-1:0]   cnt_x12;
   logic [COUNT_BITS-1:0] bodies_dec;              // bodies left after this record
   pos_type               new_pos;
   logic                  pos_equal;

   // negative counts mean none, large ones saturate to the counter width
   function automatic logic [COUNT_BITS-1:0] clamp_count(input logic [31:0] v);
      logic [31:0] hi;
      hi = v >> COUNT_BITS;
      if (v[31]) begin
         clamp_count = '0;
      end else if (hi != 32'd0) begin
         clamp_count = '1;
      end else begin
         clamp_count = v[COUNT_BITS-1:0];
      end
   endfunction

   // the last byte of a record makes an item; it waits only if the rsp slot stays full
   assign emit_pending = (phase_ff == PH_BODY) && (bif_ff == 2'd3) && (rw_ff == RW_LAST);
   assign req_stall    = rsp_valid_ff && rsp_stall && emit_pending;
   assign req_fire     = req_valid && !req_stall;

   // little-endian byte assembly
   always_comb begin
      cur_field = (bif_ff == 2'd0) ? 32'd0 : asm_ff;
      unique case (bif_ff)
         2'd0:    cur_field[7:0]   = req_data.data_byte;
         2'd1:    cur_field[15:8]  = req_data.data_byte;
         2'd2:    cur_field[23:16] = req_data.data_byte;
         default: cur_field[31:24] = req_data.data_byte;
      endcase
   end

   assign field2_done = (bif_ff >= 2'd1);
   assign field4_done = (bif_ff == 2'd3);
   assign cnt         = clamp_count(cur_field);
   assign cnt_x12     = ({4'd0, cnt} << 3) + ({4'd0, cnt} << 2);
   assign bodies_dec  = (bodies_ff != '0) ? bodies_ff - 1'b1 : '0;

   assign new_pos[0] = rec_ff[1];
   assign new_pos[1] = rec_ff[2];
   assign new_pos[2] = cur_field;

   mfrbp_pos_cmp u_pos_cmp (
      .prev_pos  (prev_pos_ff),
      .new_pos   (new_pos),
      .pos_equal (pos_equal)
   );

   // next state
   always_comb begin
      phase_in      = phase_ff;
      bif_in        = bif_ff;
      asm_in        = asm_ff;
      kind_frame_in = kind_frame_ff;
      sets_in       = sets_ff;
      skip_in       = skip_ff;
      bodies_in     = bodies_ff;
      rw_in         = rw_ff;
      seen_in       = seen_ff;
      tracked_in    = tracked_ff;
      rec_we        = 1'b0;
      frame_we      = 1'b0;
      pos_we        = 1'b0;
      emit          = 1'b0;

      if (req_fire) begin
         unique case (phase_ff)
            PH_MSG_ID: begin
               asm_in = cur_field;
               bif_in = field2_done ? 2'd0 : bif_ff + 2'd1;
               if (field2_done) begin
                  kind_frame_in = (cur_field[15:0] == FRAME_MSG_ID);
                  phase_in      = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               asm_in = cur_field;
               bif_in = field2_done ? 2'd0 : bif_ff + 2'd1;
               if (field2_done) begin
                  phase_in = kind_frame_ff ? PH_FRAME : PH_IDLE;
               end
            end
            PH_FRAME: begin
               asm_in = cur_field;
               bif_in = bif_ff + 2'd1;
               if (field4_done) begin
                  frame_we = 1'b1;
                  phase_in = PH_NSETS;
               end
            end
            PH_NSETS: begin
               asm_in = cur_field;
               bif_in = bif_ff + 2'd1;
               if (field4_done) begin
                  sets_in  = cnt;
                  phase_in = (cnt != '0) ? PH_SET_NAME : PH_OTHER_COUNT;
               end
            end
            PH_SET_NAME: begin
               if (req_data.data_byte == 8'd0) begin
                  bif_in   = 2'd0;
                  phase_in = PH_SET_COUNT;
               end
            end
            PH_SET_COUNT: begin
               asm_in = cur_field;
               bif_in = bif_ff + 2'd1;
               if (field4_done) begin
                  sets_in = (sets_ff != '0) ? sets_ff - 1'b1 : '0;
                  skip_in = cnt_x12;
                  if (cnt_x12 != '0) begin
                     phase_in = PH_SKIP_SET;
                  end else begin
                     phase_in = (sets_in != '0) ? PH_SET_NAME : PH_OTHER_COUNT;
                  end
               end
            end
            PH_SKIP_SET: begin
               skip_in = (skip_ff != '0) ? skip_ff - 1'b1 : '0;
               if (skip_in == '0) begin
                  phase_in = (sets_ff != '0) ? PH_SET_NAME : PH_OTHER_COUNT;
               end
            end
            PH_OTHER_COUNT: begin
               asm_in = cur_field;
               bif_in = bif_ff + 2'd1;
               if (field4_done) begin
                  skip_in  = cnt_x12;
                  phase_in = (cnt_x12 != '0) ? PH_SKIP_OTHER : PH_BODY_COUNT;
               end
            end
            PH_SKIP_OTHER: begin
               skip_in = (skip_ff != '0) ? skip_ff - 1'b1 : '0;
               if (skip_in == '0) begin
                  phase_in = PH_BODY_COUNT;
               end
            end
            PH_BODY_COUNT: begin
               asm_in = cur_field;
               bif_in = bif_ff + 2'd1;
               if (field4_done) begin
                  bodies_in = cnt;
                  rw_in     = '0;
                  phase_in  = (cnt != '0) ? PH_BODY : PH_IDLE;
               end
            end
            PH_BODY: begin
               asm_in = cur_field;
               bif_in = bif_ff + 2'd1;
               if (field4_done) begin
                  rec_we = (rw_ff != RW_LAST);
                  if (rw_ff == RW_POS_Z) begin
                     // tracking: first body only seeds the stored position
                     pos_we  = 1'b1;
                     seen_in = 1'b1;
                     if (seen_ff) begin
                        tracked_in = !pos_equal;
                     end
                  end
                  if (rw_ff == RW_LAST) begin
                     emit      = 1'b1;
                     bodies_in = bodies_dec;
                     rw_in     = '0;
                     if (bodies_dec == '0) begin
                        phase_in = PH_IDLE;
                     end
                  end else begin
                     rw_in = rw_ff + 1'b1;
                  end
               end
            end
            PH_IDLE: begin
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // end of packet: partial data dropped, back to the message id
         if (req_data.end_of_packet) begin
            phase_in  = PH_MSG_ID;
            bif_in    = 2'd0;
            asm_in    = 32'd0;
            sets_in   = '0;
            skip_in   = '0;
            bodies_in = '0;
            rw_in     = '0;
         end
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MSG_ID;
         bif_ff        <= 2'd0;
         asm_ff        <= 32'd0;
         kind_frame_ff <= 1'b0;
         sets_ff       <= '0;
         skip_ff       <= '0;
         bodies_ff     <= '0;
         rw_ff         <= '0;
         seen_ff       <= 1'b0;
         tracked_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bif_ff        <= bif_in;
         asm_ff        <= asm_in;
         kind_frame_ff <= kind_frame_in;
         sets_ff       <= sets_in;
         skip_ff       <= skip_in;
         bodies_ff     <= bodies_in;
         rw_ff         <= rw_in;
         seen_ff       <= seen_in;
         tracked_ff    <= tracked_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_ff[rw_ff[2:0]] <= cur_field;
      end
      if (frame_we) begin
         frame_ff <= cur_field;
      end
      if (pos_we) begin
         prev_pos_ff <= new_pos;
      end
      if (emit) begin
         rsp_data_ff.body_id      <= rec_ff[0];
         rsp_data_ff.frame_number <= frame_ff;
         rsp_data_ff.pos_x        <= rec_ff[1];
         rsp_data_ff.pos_y        <= rec_ff[2];
         rsp_data_ff.pos_z        <= rec_ff[3];
         rsp_data_ff.quat_x       <= rec_ff[4];
         rsp_data_ff.quat_y       <= rec_ff[5];
         rsp_data_ff.quat_z       <= rec_ff[6];
         rsp_data_ff.quat_w       <= rec_ff[7];
         rsp_data_ff.mean_error   <= cur_field;
         rsp_data_ff.tracked      <= tracked_ff;
         rsp_data_ff.last_body    <= (bodies_dec == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // end of packet always returns to the message id with an empty field
   a_eop_rewind: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.end_of_packet |=> phase_ff == PH_MSG_ID && bif_ff == 2'd0)
      else $error("parser did not rewind on end of packet");

   // a new item never lands on a held, stalled item
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || !rsp_stall)
      else $error("result register overwritten while stalled");

   // body records are only parsed with bodies still to come
   a_body_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> bodies_ff != '0)
      else $error("body phase with zero bodies left");

   // skip phases always have bytes left to skip
   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP_SET || phase_ff == PH_SKIP_OTHER |-> skip_ff != '0)
      else $error("skip phase with nothing to skip");

endmodule
`default_nettype wire

// File: hdl/mfrbp_pos_cmp.sv
// float equality of two 3-component positions (+0 equals -0, nan never equal)
`default_nettype none
module mfrbp_pos_cmp (
   input  mfrbp_pkg::pos_type prev_pos,
   input  mfrbp_pkg::pos_type new_pos,
   output logic               pos_equal
);
   import mfrbp_pkg::*;

   logic [2:0] lane_eq;

   function automatic logic is_nan(input logic [31:0] a);
      is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (is_nan(prev_pos[i]) || is_nan(new_pos[i])) begin
            lane_eq[i] = 1'b0;
         end else if ((prev_pos[i][30:0] == 31'd0) && (new_pos[i][30:0] == 31'd0)) begin
            lane_eq[i] = 1'b1;
         end else begin
            lane_eq[i] = (prev_pos[i] == new_pos[i]);
         end
      end
   end

   assign pos_equal = &lane_eq;

endmodule
`default_nettype wire
